FILE: rtl/core/eshs_pkg.sv
// shared types and constants for the echo-seeking head sweep
// no dependencies; used by the channel interfaces and the top level
package eshs_pkg;

    // field widths fixed by the item formats
    localparam int DIST_W  = 14;
    localparam int ANGLE_W = 8;
    localparam int STEP_W  = 9;
    localparam int SUM_W   = 10;
    localparam int CFG_W   = 16;

    typedef logic [DIST_W-1:0]         t_dist;
    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic signed [STEP_W-1:0]  t_step;
    typedef logic signed [SUM_W-1:0]   t_angle_sum;

    // request kinds
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_ALIGN = 2'd1,
        ACT_SCAN  = 2'd2,
        ACT_ECHO  = 2'd3
    } t_action;

    // operating mode of the head
    typedef enum logic [1:0] {
        MODE_MONITOR = 2'd0,
        MODE_ALIGN   = 2'd1,
        MODE_SCAN    = 2'd2
    } t_mode;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SACCADE_SPAN      = 2'd0,
        CFG_SACCADE_PERIOD    = 2'd1,
        CFG_MONITOR_PERIOD    = 2'd2,
        CFG_MONITOR_VARIATION = 2'd3
    } t_cfg_idx;

    // distance mm = floor(us * 0.1657), done as us * ceil(0.1657 * 2^32) >> 32
    // exact for every 14-bit pulse width
    localparam int              RECIP_W    = 30;
    localparam logic [29:0]     DIST_RECIP = 30'd711676081;
    localparam int              DIST_SHIFT = 32;
    localparam int              PROD_W     = DIST_W + RECIP_W;

    // distance seeds used when alignment starts
    localparam t_dist PEN_START  = 14'd1;
    localparam t_dist PREV_START = 14'd10001;

    // reset values of the configuration registers
    localparam logic [6:0]        SPAN_RST      = 7'd10;
    localparam logic [CFG_W-1:0]  SACC_PER_RST  = 16'd100;
    localparam logic [CFG_W-1:0]  MON_PER_RST   = 16'd200;
    localparam t_dist             MON_VAR_RST   = 14'd50;

endpackage

FILE: rtl/core/eshs_in_if.sv
// input channel: one request per handshake (action code and echo width)
// depends on eshs_pkg
interface eshs_in_if;
    import eshs_pkg::*;

    logic    valid;
    logic    ready;
    t_action action;
    t_dist   echo_us;

    modport source (output valid, action, echo_us, input ready);
    modport sink   (input valid, action, echo_us, output ready);
endinterface

FILE: rtl/core/eshs_out_if.sv
// result channel: head state and scan sample after each request
// depends on eshs_pkg
interface eshs_out_if;
    import eshs_pkg::*;

    logic       valid;
    logic       ready;
    logic       measure_request;
    logic       servo_write;
    t_angle     servo_angle;
    logic       aligning;
    logic       scanning;
    t_dist      min_distance;
    logic       sample_valid;
    logic [6:0] sample_index;
    t_angle     sample_angle;
    t_dist      sample_distance;

    modport source (
        output valid, measure_request, servo_write, servo_angle, aligning, scanning,
               min_distance, sample_valid, sample_index, sample_angle, sample_distance,
        input  ready
    );
    modport sink (
        input  valid, measure_request, servo_write, servo_angle, aligning, scanning,
               min_distance, sample_valid, sample_index, sample_angle, sample_distance,
        output ready
    );
endinterface

FILE: rtl/core/echo_seeking_head_sweep.sv
// Echo-seeking head sweep: one request in, one result out. Throughput is one request per
// clock while the sink keeps up. The first register holds the request with the echo width
// already converted to millimetres (one 14x30 multiply in front of it); the second stage
// applies the tick, start or echo step to the mode state and loads the result register.
// The result register holds while the sink stalls, and the input register keeps taking a
// request as long as it is empty or moving on. Write configuration only while idle.
// depends on eshs_pkg, eshs_in_if, eshs_out_if
module echo_seeking_head_sweep #(
    parameter int ANGLE_LIMIT  = 90,
    parameter int SCAN_POINTS  = 128,
    parameter int FAR_DISTANCE = 10000
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  eshs_pkg::t_cfg_idx        i_cfg_idx,
    input  logic [eshs_pkg::CFG_W-1:0] i_cfg_data,
    eshs_in_if.sink                   i_item,
    eshs_out_if.source                o_result
);
    import eshs_pkg::*;

    localparam int         PW     = $clog2(SCAN_POINTS);
    localparam t_angle_sum LIM    = SUM_W'(ANGLE_LIMIT);
    localparam t_angle     LIM_A  = ANGLE_W'(ANGLE_LIMIT);
    localparam t_dist      FAR    = DIST_W'(FAR_DISTANCE);
    localparam logic [PW-1:0] POS_LAST = PW'(SCAN_POINTS - 1);

    typedef struct packed {
        logic       measure_request;
        logic       servo_write;
        t_angle     servo_angle;
        logic       aligning;
        logic       scanning;
        t_dist      min_distance;
        logic       sample_valid;
        logic [6:0] sample_index;
        t_angle     sample_angle;
        t_dist      sample_distance;
    } t_result;

    // configuration
    logic [6:0]       r_span;
    logic [CFG_W-1:0] r_sacc_per;
    logic [CFG_W-1:0] r_mon_per;
    t_dist            r_mon_var;

    // pipeline control and payload
    logic    r_s1_vld;
    t_action r_s1_action;
    t_dist   r_s1_dist;
    logic    r_out_vld;
    t_result r_out;
    logic    out_free;
    logic    advance;
    logic    take_in;

    // head state
    t_mode         r_mode, n_mode;
    logic          r_await, n_await;
    logic [CFG_W-1:0] r_elapsed, n_elapsed;
    logic          r_wim, n_wim;
    t_angle        r_head, n_head;
    t_step         r_step, n_step;
    logic [1:0]    r_sc, n_sc;
    t_dist         r_prev, n_prev;
    t_dist         r_pen, n_pen;
    t_dist         r_best, n_best;
    t_angle        r_best_ang, n_best_ang;
    logic [PW-1:0] r_pos, n_pos;

    // per-request flags from the step logic
    logic    n_servo_wr;
    logic    n_sample;
    t_result n_result;

    // datapath helpers
    logic [PROD_W-1:0] dist_prod;
    t_dist             dist_raw;
    t_dist             dist_mm;
    logic [1:0]        sc_inc;
    t_angle_sum        sum_fwd;
    t_angle_sum        sum_rev;
    t_angle            turn_fwd;
    t_angle            turn_rev;
    t_step             span2;
    logic [CFG_W-1:0]  period;
    t_dist             drift;
    logic              head_at_lim;
    logic              scan_out;

    function automatic t_angle clamp_angle(input t_angle_sum a);
        t_angle res;
        if (a > LIM) begin
            res = LIM_A;
        end else if (a < -LIM) begin
            res = -LIM_A;
        end else begin
            res = ANGLE_W'(a);
        end
        return res;
    endfunction

    // echo width to millimetres, a zero result (timeout or very short pulse) reads as far away
    assign dist_prod = PROD_W'(i_item.echo_us) * PROD_W'(DIST_RECIP);
    assign dist_raw  = DIST_W'(dist_prod[PROD_W-1:DIST_SHIFT]);
    assign dist_mm   = (dist_raw == '0) ? FAR : dist_raw;

    // handshake
    assign out_free     = !r_out_vld || o_result.ready;
    assign advance      = r_s1_vld && out_free;
    assign i_item.ready = !r_s1_vld || advance;
    assign take_in      = i_item.valid && i_item.ready;

    // shared step terms
    assign sc_inc      = (r_sc == 2'd3) ? r_sc : r_sc + 2'd1;
    assign sum_fwd     = SUM_W'(r_head) + SUM_W'(r_step);
    assign sum_rev     = SUM_W'(r_head) - SUM_W'(r_step);
    assign turn_fwd    = clamp_angle(sum_fwd);
    assign turn_rev    = clamp_angle(sum_rev);
    assign span2       = STEP_W'({r_span, 1'b0});
    assign period      = r_wim ? r_mon_per : r_sacc_per;
    assign drift       = (r_s1_dist >= r_best) ? r_s1_dist - r_best : r_best - r_s1_dist;
    assign head_at_lim = (SUM_W'(r_head) <= -LIM) || (SUM_W'(r_head) >= LIM);
    assign scan_out    = (sum_fwd > LIM) || (sum_fwd < -LIM);

    // next state
    always_comb begin
        n_mode     = r_mode;
        n_await    = r_await;
        n_elapsed  = r_elapsed;
        n_wim      = r_wim;
        n_head     = r_head;
        n_step     = r_step;
        n_sc       = r_sc;
        n_prev     = r_prev;
        n_pen      = r_pen;
        n_best     = r_best;
        n_best_ang = r_best_ang;
        n_pos      = r_pos;
        n_servo_wr = 1'b0;
        n_sample   = 1'b0;
        case (r_s1_action)
            ACT_TICK: begin
                if (!r_await) begin
                    if (r_elapsed >= period) begin
                        n_await = 1'b1;
                    end else begin
                        n_elapsed = r_elapsed + 1'b1;
                    end
                end
            end
            ACT_ALIGN: begin
                n_mode    = MODE_ALIGN;
                n_pen     = PEN_START;
                n_prev    = PREV_START;
                n_step    = STEP_W'(r_span);
                n_sc      = '0;
                n_elapsed = '0;
                n_wim     = 1'b0;
                n_await   = 1'b0;
            end
            ACT_SCAN: begin
                n_mode     = MODE_SCAN;
                n_best     = FAR;
                if (r_head > 0) begin
                    n_best_ang = LIM_A;
                    n_step     = -span2;
                end else begin
                    n_best_ang = -LIM_A;
                    n_step     = span2;
                end
                n_head     = n_best_ang;
                n_servo_wr = 1'b1;
                n_elapsed  = '0;
                n_wim      = 1'b0;
                n_await    = 1'b0;
                n_sc       = '0;
                n_pos      = '0;
            end
            ACT_ECHO: begin
                if (r_await) begin
                    n_elapsed = '0;
                    n_await   = 1'b0;
                    case (r_mode)
                        // hill-climb toward the nearest echo
                        MODE_ALIGN: begin
                            n_sc  = sc_inc;
                            n_wim = 1'b0;
                            if (r_prev > r_s1_dist) begin
                                if (head_at_lim) begin
                                    if (sc_inc > 2'd1) begin
                                        n_best = r_s1_dist;
                                        n_mode = MODE_MONITOR;
                                        n_wim  = 1'b1;
                                    end else begin
                                        n_step     = -r_step;
                                        n_head     = turn_rev;
                                        n_servo_wr = 1'b1;
                                    end
                                end else begin
                                    n_head     = turn_fwd;
                                    n_servo_wr = 1'b1;
                                end
                            end else begin
                                n_step     = -r_step;
                                n_head     = turn_rev;
                                n_servo_wr = 1'b1;
                                if (r_pen >= r_prev && sc_inc > 2'd2) begin
                                    n_best = r_prev;
                                    n_mode = MODE_MONITOR;
                                    n_wim  = 1'b1;
                                end
                            end
                            n_pen  = r_prev;
                            n_prev = r_s1_dist;
                        end
                        // sweep one step and keep the closest angle
                        MODE_SCAN: begin
                            n_sc     = sc_inc;
                            n_wim    = 1'b0;
                            n_sample = 1'b1;
                            if (r_s1_dist < r_best) begin
                                n_best     = r_s1_dist;
                                n_best_ang = r_head;
                            end
                            n_pos = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
                            if (scan_out) begin
                                n_mode = MODE_MONITOR;
                                n_wim  = 1'b1;
                                n_head = n_best_ang;
                            end else begin
                                n_head = turn_fwd;
                            end
                            n_servo_wr = 1'b1;
                        end
                        // watch for drift, restart alignment past the limit
                        default: begin
                            n_wim = 1'b1;
                            if (drift > r_mon_var) begin
                                n_mode = MODE_ALIGN;
                                n_pen  = PEN_START;
                                n_prev = PREV_START;
                                n_step = STEP_W'(r_span);
                                n_sc   = '0;
                                n_wim  = 1'b0;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    // result fields
    always_comb begin
        n_result.measure_request = n_await;
        n_result.servo_write     = n_servo_wr;
        n_result.servo_angle     = n_head;
        n_result.aligning        = (n_mode == MODE_ALIGN);
        n_result.scanning        = (n_mode == MODE_SCAN);
        n_result.min_distance    = n_best;
        n_result.sample_valid    = n_sample;
        n_result.sample_index    = n_sample ? 7'(r_pos) : '0;
        n_result.sample_angle    = n_sample ? r_head : '0;
        n_result.sample_distance = n_sample ? r_s1_dist : '0;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span     <= SPAN_RST;
            r_sacc_per <= SACC_PER_RST;
            r_mon_per  <= MON_PER_RST;
            r_mon_var  <= MON_VAR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SACCADE_SPAN:      r_span     <= i_cfg_data[6:0];
                CFG_SACCADE_PERIOD:    r_sacc_per <= i_cfg_data;
                CFG_MONITOR_PERIOD:    r_mon_per  <= i_cfg_data;
                CFG_MONITOR_VARIATION: r_mon_var  <= i_cfg_data[DIST_W-1:0];
                default:               r_span     <= r_span;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (take_in) begin
            r_s1_vld <= 1'b1;
        end else if (advance) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_s1_action <= i_item.action;
            r_s1_dist   <= dist_mm;
        end
    end

    // mode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_MONITOR;
            r_await    <= 1'b0;
            r_elapsed  <= '0;
            r_wim      <= 1'b0;
            r_head     <= '0;
            r_step     <= STEP_W'(SPAN_RST);
            r_sc       <= '0;
            r_prev     <= DIST_W'(1);
            r_pen      <= '0;
            r_best     <= '0;
            r_best_ang <= '0;
            r_pos      <= '0;
        end else if (advance) begin
            r_mode     <= n_mode;
            r_await    <= n_await;
            r_elapsed  <= n_elapsed;
            r_wim      <= n_wim;
            r_head     <= n_head;
            r_step     <= n_step;
            r_sc       <= n_sc;
            r_prev     <= n_prev;
            r_pen      <= n_pen;
            r_best     <= n_best;
            r_best_ang <= n_best_ang;
            r_pos      <= n_pos;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_result;
        end
    end

    assign o_result.valid           = r_out_vld;
    assign o_result.measure_request = r_out.measure_request;
    assign o_result.servo_write     = r_out.servo_write;
    assign o_result.servo_angle     = r_out.servo_angle;
    assign o_result.aligning        = r_out.aligning;
    assign o_result.scanning        = r_out.scanning;
    assign o_result.min_distance    = r_out.min_distance;
    assign o_result.sample_valid    = r_out.sample_valid;
    assign o_result.sample_index    = r_out.sample_index;
    assign o_result.sample_angle    = r_out.sample_angle;
    assign o_result.sample_distance = r_out.sample_distance;

endmodule

FILE: tb/echo_seeking_head_sweep_tb.sv
`timescale 1ns / 100ps
// testbench for echo_seeking_head_sweep: directed and random requests checked field by field
// against a behavioral model of the head state kept in this file
// depends on eshs_pkg, eshs_in_if, eshs_out_if and the rtl top level
module echo_seeking_head_sweep_tb;
    import eshs_pkg::*;

    localparam int ANGLE_LIM    = 90;
    localparam int SCAN_PTS     = 128;
    localparam int FAR_MM       = 10000;
    localparam int PIPE_CYCLES  = 4;
    localparam int STALL_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic       measure_request;
        logic       servo_write;
        t_angle     servo_angle;
        logic       aligning;
        logic       scanning;
        t_dist      min_distance;
        logic       sample_valid;
        logic [6:0] sample_index;
        t_angle     sample_angle;
        t_dist      sample_distance;
    } t_head_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    t_cfg_idx         i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    eshs_in_if  req_if();
    eshs_out_if res_if();

    echo_seeking_head_sweep #(
        .ANGLE_LIMIT  (ANGLE_LIM),
        .SCAN_POINTS  (SCAN_PTS),
        .FAR_DISTANCE (FAR_MM)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (req_if),
        .o_result   (res_if)
    );

    // expected results in request order, shared bookkeeping
    t_head_result results_due[$];
    int           n_errors    = 0;
    int           n_effective = 0;
    int           n_cycles    = 0;
    int           stall_seq   = 0;
    bit           steady      = 1'b0;
    int           hot_spot    = 0;

    // model copy of the registers
    int unsigned cfg_span, cfg_sacc_per, cfg_mon_per, cfg_mon_var;

    // model copy of the head state
    t_mode       m_mode;
    bit          m_pending;
    int unsigned m_elapsed_ms;
    bit          m_monitor_wait;
    int          m_head;
    int          m_step;
    int unsigned m_nsteps;
    int          m_last_mm, m_older_mm, m_best_mm, m_best_head;
    int unsigned m_sample_pos;
    bit          m_servo_moved;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("echo_seeking_head_sweep: mismatch");
            $finish;
        end
    end

    function automatic void reset_model();
        cfg_span       = SPAN_RST;
        cfg_sacc_per   = SACC_PER_RST;
        cfg_mon_per    = MON_PER_RST;
        cfg_mon_var    = MON_VAR_RST;
        m_mode         = MODE_MONITOR;
        m_pending      = 1'b0;
        m_elapsed_ms   = 0;
        m_monitor_wait = 1'b0;
        m_head         = 0;
        m_step         = 10;
        m_nsteps       = 0;
        m_last_mm      = 1;
        m_older_mm     = 0;
        m_best_mm      = 0;
        m_best_head    = 0;
        m_sample_pos   = 0;
        m_servo_moved  = 1'b0;
    endfunction

    // pulse width in us to mm, timeout and tiny pulses read as far
    function automatic int echo_to_mm(input int unsigned us);
        int mm;
        mm = int'((us * 1657) / 10000);
        return (mm == 0) ? FAR_MM : mm;
    endfunction

    function automatic void turn_to(input int a);
        if (a > ANGLE_LIM) a = ANGLE_LIM;
        if (a < -ANGLE_LIM) a = -ANGLE_LIM;
        m_head        = a;
        m_servo_moved = 1'b1;
    endfunction

    function automatic void rewait(input bit monitor);
        m_elapsed_ms   = 0;
        m_monitor_wait = monitor;
        m_pending      = 1'b0;
    endfunction

    function automatic void count_step();
        if (m_nsteps < 65535) m_nsteps++;
    endfunction

    function automatic void start_align();
        m_mode     = MODE_ALIGN;
        m_older_mm = 1;
        m_last_mm  = 10001;
        m_step     = int'(cfg_span);
        m_nsteps   = 0;
        rewait(1'b0);
    endfunction

    function automatic void start_scan();
        m_mode    = MODE_SCAN;
        m_best_mm = FAR_MM;
        if (m_head > 0) begin
            m_best_head = ANGLE_LIM;
            m_step      = -2 * int'(cfg_span);
        end else begin
            m_best_head = -ANGLE_LIM;
            m_step      = 2 * int'(cfg_span);
        end
        turn_to(m_best_head);
        rewait(1'b0);
        m_nsteps     = 0;
        m_sample_pos = 0;
    endfunction

    // one alignment step: follow the slope, settle once past the minimum
    function automatic void hill_climb(input int mm);
        count_step();
        rewait(1'b0);
        if (m_last_mm > mm) begin
            if (m_head <= -ANGLE_LIM || m_head >= ANGLE_LIM) begin
                if (m_nsteps > 1) begin
                    m_best_mm      = mm;
                    m_mode         = MODE_MONITOR;
                    m_monitor_wait = 1'b1;
                end else begin
                    m_step = -m_step;
                    turn_to(m_head + m_step);
                end
            end else begin
                turn_to(m_head + m_step);
            end
        end else begin
            m_step = -m_step;
            turn_to(m_head + m_step);
            if (m_older_mm >= m_last_mm && m_nsteps > 2) begin
                m_best_mm      = m_last_mm;
                m_mode         = MODE_MONITOR;
                m_monitor_wait = 1'b1;
            end
        end
        m_older_mm = m_last_mm;
        m_last_mm  = mm;
    endfunction

    // applies one request to the model; returns 0 when the request is ignored
    function automatic bit predict_head(input t_action act, input int unsigned us,
                                        output t_head_result res);
        bit          took;
        bit          smp;
        int unsigned s_pos;
        int unsigned period;
        int          s_ang, s_mm, mm, nxt, drift;
        took          = 1'b1;
        smp           = 1'b0;
        s_pos         = 0;
        s_ang         = 0;
        s_mm          = 0;
        m_servo_moved = 1'b0;
        case (act)
            ACT_TICK: begin
                if (m_pending) begin
                    took = 1'b0;
                end else begin
                    period = m_monitor_wait ? cfg_mon_per : cfg_sacc_per;
                    if (m_elapsed_ms >= period) m_pending = 1'b1;
                    else m_elapsed_ms++;
                end
            end
            ACT_ALIGN: start_align();
            ACT_SCAN:  start_scan();
            ACT_ECHO: begin
                if (!m_pending) begin
                    took = 1'b0;
                end else begin
                    mm = echo_to_mm(us);
                    if (m_mode == MODE_ALIGN) begin
                        hill_climb(mm);
                    end else if (m_mode == MODE_SCAN) begin
                        count_step();
                        rewait(1'b0);
                        if (mm < m_best_mm) begin
                            m_best_mm   = mm;
                            m_best_head = m_head;
                        end
                        smp          = 1'b1;
                        s_pos        = m_sample_pos;
                        s_ang        = m_head;
                        s_mm         = mm;
                        m_sample_pos = (m_sample_pos + 1) % SCAN_PTS;
                        nxt          = m_head + m_step;
                        // end of sweep: park the head on the closest angle
                        if (nxt > ANGLE_LIM || nxt < -ANGLE_LIM) begin
                            m_mode         = MODE_MONITOR;
                            nxt            = m_best_head;
                            m_monitor_wait = 1'b1;
                        end
                        turn_to(nxt);
                    end else begin
                        drift = mm - m_best_mm;
                        if (drift < 0) drift = -drift;
                        rewait(1'b1);
                        if (drift > int'(cfg_mon_var)) start_align();
                    end
                end
            end
            default: ;
        endcase
        res.measure_request = m_pending;
        res.servo_write     = m_servo_moved;
        res.servo_angle     = t_angle'(m_head);
        res.aligning        = (m_mode == MODE_ALIGN);
        res.scanning        = (m_mode == MODE_SCAN);
        res.min_distance    = t_dist'(m_best_mm);
        res.sample_valid    = smp;
        res.sample_index    = 7'(s_pos);
        res.sample_angle    = t_angle'(s_ang);
        res.sample_distance = t_dist'(s_mm);
        return took;
    endfunction

    function automatic string show(input t_head_result r);
        return $sformatf({"req=%0d srv=%0d ang=%0d al=%0d sc=%0d min=%0d ",
                          "smp=%0d idx=%0d sang=%0d sd=%0d"},
                         r.measure_request, r.servo_write, $signed(r.servo_angle), r.aligning,
                         r.scanning, r.min_distance, r.sample_valid, r.sample_index,
                         $signed(r.sample_angle), r.sample_distance);
    endfunction

    // result sink: random stalls, long hold-offs on demand, check of each result
    initial begin
        t_head_result want, got;
        int           stall_seen;
        int           hold_left;
        stall_seen   = 0;
        hold_left    = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                got.measure_request = res_if.measure_request;
                got.servo_write     = res_if.servo_write;
                got.servo_angle     = res_if.servo_angle;
                got.aligning        = res_if.aligning;
                got.scanning        = res_if.scanning;
                got.min_distance    = res_if.min_distance;
                got.sample_valid    = res_if.sample_valid;
                got.sample_index    = res_if.sample_index;
                got.sample_angle    = res_if.sample_angle;
                got.sample_distance = res_if.sample_distance;
                if (results_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= REPORT_MAX)
                        $display("result with no request outstanding: %s", show(got));
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= REPORT_MAX) begin
                            $display("expected %s", show(want));
                            $display("actual   %s", show(got));
                        end
                    end
                end
            end
            if (stall_seq != stall_seen) begin
                stall_seen = stall_seq;
                hold_left  = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= steady || ($urandom_range(99) >= 36);
            end
        end
    end

    // offers one request, waits for it to be taken, records its expected result
    task automatic send_request(input t_action act, input int unsigned us);
        t_head_result res;
        if (!steady) begin
            while ($urandom_range(99) < 36) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_if.valid   <= 1'b1;
        req_if.action  <= act;
        req_if.echo_us <= t_dist'(us);
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        if (predict_head(act, us, res)) n_effective++;
        results_due.push_back(res);
    endtask

    // stop offering and wait until every expected result is back
    task automatic settle();
        req_if.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[CFG_W-1:0];
        @(posedge i_clk);
        case (idx)
            CFG_SACCADE_SPAN:      cfg_span     = val[6:0];
            CFG_SACCADE_PERIOD:    cfg_sacc_per = val[15:0];
            CFG_MONITOR_PERIOD:    cfg_mon_per  = val[15:0];
            CFG_MONITOR_VARIATION: cfg_mon_var  = val[13:0];
            default: ;
        endcase
    endtask

    task automatic set_registers(input int unsigned span, input int unsigned sacc,
                                 input int unsigned mon, input int unsigned drift);
        settle();
        write_reg(CFG_SACCADE_SPAN, span);
        write_reg(CFG_SACCADE_PERIOD, sacc);
        write_reg(CFG_MONITOR_PERIOD, mon);
        write_reg(CFG_MONITOR_VARIATION, drift);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // echo widths: mostly a distance profile around a moving target, plus extremes
    function automatic int unsigned pick_echo();
        int r, off;
        r   = $urandom_range(99);
        off = m_head - hot_spot;
        if (off < 0) off = -off;
        if (r < 8) return 0;
        if (r < 14) return $urandom_range(16383);
        if (r < 18) return $urandom_range(16383, 10000);
        return 600 + 45 * off + $urandom_range(40);
    endfunction

    // mostly well-formed tick/echo sequences, with stray echoes and ticks as noise and start commands at cmd_pct
    task automatic random_burst(input int n, input int cmd_pct);
        int          goal, sent, r;
        t_action     act;
        goal = n_effective + n;
        sent = 0;
        while (n_effective < goal && sent < 4 * n) begin
            r = $urandom_range(99);
            if (r < cmd_pct) act = $urandom_range(1) ? ACT_SCAN : ACT_ALIGN;
            else if (m_pending) act = (r < 88) ? ACT_ECHO : ACT_TICK;
            else act = (r < 94) ? ACT_TICK : ACT_ECHO;
            if ($urandom_range(49) == 0) hot_spot = $urandom_range(180) - 90;
            send_request(act, pick_echo());
            sent++;
        end
    endtask

    // timing, ignored requests, distance extremes, start commands and mode changes
    task automatic test_directed_cases();
        set_registers(10, 0, 0, 50);
        send_request(ACT_ECHO, 500);    // echo with no request pending is dropped
        send_request(ACT_TICK, 0);      // zero period raises the request at once
        send_request(ACT_TICK, 0);      // tick while pending is dropped
        send_request(ACT_ECHO, 0);      // timeout reads far, drift starts alignment
        send_request(ACT_TICK, 0);
        send_request(ACT_ECHO, 16383);  // widest pulse, head climbs
        send_request(ACT_TICK, 0);
        send_request(ACT_ALIGN, 0);     // start command drops the pending request
        send_request(ACT_SCAN, 9999);   // head right of center, sweep from the right
        send_request(ACT_TICK, 0);
        send_request(ACT_ECHO, 6);      // rounds to zero mm, reads far
        send_request(ACT_TICK, 0);
        send_request(ACT_ECHO, 7);      // smallest nonzero distance
        send_request(ACT_TICK, 0);
        send_request(ACT_ECHO, 10000);
        send_request(ACT_ALIGN, 0);     // alignment abandons the scan
        send_request(ACT_TICK, 0);
        send_request(ACT_ECHO, 3000);
        send_request(ACT_SCAN, 0);
        send_request(ACT_TICK, 0);
        send_request(ACT_ECHO, 12345);
        send_request(ACT_TICK, 0);
        send_request(ACT_ECHO, 1);
    endtask

    // register extremes, each followed by random traffic
    task automatic test_settings_sweep();
        // zero span: the scan never ends and the sample index wraps
        set_registers(0, 0, 0, 0);
        send_request(ACT_SCAN, 0);
        random_burst(400, 0);
        set_registers(1, 1, 2, 16383);
        send_request(ACT_SCAN, 0);
        random_burst(250, 2);
        set_registers(90, 0, 1, 10000);
        random_burst(150, 3);
        set_registers(127, 2, 0, 1);
        random_burst(150, 3);
        set_registers(SPAN_RST, SACC_PER_RST, MON_PER_RST, MON_VAR_RST);
        random_burst(250, 1);
        set_registers(45, 65535, 65535, 8191);
        random_burst(40, 5);
    endtask

    // long result stall while requests keep coming, then a full drain
    task automatic test_result_backpressure();
        set_registers(20, 1, 1, 30);
        stall_seq++;
        random_burst(60, 3);
        settle();
        steady = 1'b1;
        stall_seq++;
        random_burst(60, 3);
        steady = 1'b0;
        settle();
    endtask

    // random register settings with random traffic, one stretch without idling
    task automatic test_random_traffic();
        int unsigned span;
        for (int k = 0; k < 6; k++) begin
            span = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(90, 1);
            set_registers(span, $urandom_range(4), $urandom_range(6), $urandom_range(300));
            steady = (k == 2);
            random_burst(100, 2);
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_SACCADE_SPAN;
        i_cfg_data     <= '0;
        req_if.valid   <= 1'b0;
        req_if.action  <= ACT_TICK;
        req_if.echo_us <= '0;
        reset_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_settings_sweep();
        test_result_backpressure();
        test_random_traffic();

        settle();
        repeat (4 * PIPE_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("echo_seeking_head_sweep: match");
        end else begin
            $display("echo_seeking_head_sweep: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/eshs_pkg.sv
rtl/core/eshs_in_if.sv
rtl/core/eshs_out_if.sv
rtl/core/echo_seeking_head_sweep.sv
tb/echo_seeking_head_sweep_tb.sv
